// ----- design/soft_timer_table_unit_defines.svh -----
// assertion macros used by the checker file of the soft timer table
`ifndef SOFT_TIMER_TABLE_UNIT_DEFINES_SVH
`define SOFT_TIMER_TABLE_UNIT_DEFINES_SVH

// property checked while out of reset
`define STT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/stt_pkg.sv -----
// shared constants, codes and types of the soft timer table
package stt_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int COUNT_BITS = 32;
  localparam int FUNC_W     = 3;
  localparam int SLOT_W     = 4;
  localparam int TICK_W     = 32;
  localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WALK_W     = $clog2(NUM_SLOTS + 1);

  // operation codes
  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CREATE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PAUSE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESUME = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RESET  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd6;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // request to the count and reload store
  typedef struct packed {
    idx_t   rd_addr;
    logic   we_cnt;
    logic   we_rel;
    idx_t   wr_addr;
    count_t wr_cnt;
    count_t wr_rel;
  } mem_req_t;

  // outcome of one slot update
  typedef struct packed {
    count_t next_cnt;
    logic   hit;
  } dec_res_t;

endpackage

// ----- design/stt_mem.sv -----
// count and reload store, one write and one registered read per cycle
module stt_mem (
  input  logic              clk_i,
  input  stt_pkg::mem_req_t req_i,
  output stt_pkg::count_t   rd_cnt_o,
  output stt_pkg::count_t   rd_rel_o
);

  stt_pkg::count_t cnt_mem [stt_pkg::NUM_SLOTS];
  stt_pkg::count_t rel_mem [stt_pkg::NUM_SLOTS];
  stt_pkg::count_t rd_cnt_q;
  stt_pkg::count_t rd_rel_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we_cnt) begin
      cnt_mem[req_i.wr_addr] <= req_i.wr_cnt;
    end
    if (req_i.we_rel) begin
      rel_mem[req_i.wr_addr] <= req_i.wr_rel;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_cnt_q <= cnt_mem[req_i.rd_addr];
    rd_rel_q <= rel_mem[req_i.rd_addr];
  end

  assign rd_cnt_o = rd_cnt_q;
  assign rd_rel_o = rd_rel_q;

endmodule

// ----- design/stt_dec.sv -----
// shared slot update unit: saturating decrement, zero detect, reload select
module stt_dec (
  input  stt_pkg::count_t   cnt_i,
  input  stt_pkg::count_t   reload_i,
  output stt_pkg::dec_res_t res_o
);

  stt_pkg::count_t dec_cnt;

  // count stops at zero
  assign dec_cnt = (cnt_i != '0) ? (cnt_i - 1'b1) : cnt_i;

  // expiry reloads the count
  assign res_o.hit      = (dec_cnt == '0);
  assign res_o.next_cnt = res_o.hit ? reload_i : dec_cnt;

endmodule

// ----- design/soft_timer_table_unit.sv -----
// top level of the soft timer table: sequencer, slot flags and result register
//
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// command   | start / busy               | func_i slot_i reload_value_i auto_reload_i
//           |                            | start_running_i
// result    | res_strobe_o (one cycle)   | timer_slot_o expired_o error_o running_o
//           |                            | ticks_o last_o
//
// a tick walks the slots through the one update unit, one slot a cycle on the
// store's read port: busy stays high through the walk and its final report.
// any other operation reads its slot once and holds busy until it has acted on it.
// results appear in the cycle after they are formed; the receiver cannot stall.
// reset clears the flags and tick count at once; the store needs no clearing.
module soft_timer_table_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [stt_pkg::FUNC_W-1:0]  func_i,
  input  logic [stt_pkg::SLOT_W-1:0]  slot_i,
  input  logic [31:0]                 reload_value_i,
  input  logic                        auto_reload_i,
  input  logic                        start_running_i,
  output logic                        res_strobe_o,
  output logic [stt_pkg::SLOT_W-1:0]  timer_slot_o,
  output logic                        expired_o,
  output logic                        error_o,
  output logic                        running_o,
  output logic [stt_pkg::TICK_W-1:0]  ticks_o,
  output logic                        last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  // captured command beat
  logic [stt_pkg::FUNC_W-1:0] func_q;
  logic [stt_pkg::SLOT_W-1:0] slot_q;
  stt_pkg::count_t            rel_val_q;
  logic                       ar_q;
  logic                       sr_q;

  // per-slot flags
  logic [stt_pkg::NUM_SLOTS-1:0] valid_q, valid_d;
  logic [stt_pkg::NUM_SLOTS-1:0] en_q, en_d;
  logic [stt_pkg::NUM_SLOTS-1:0] arl_q, arl_d;

  logic [stt_pkg::TICK_W-1:0] ticks_q, ticks_d;
  logic [stt_pkg::WALK_W-1:0] walk_q, walk_d;
  logic                       pend_vld_q, pend_vld_d;
  logic [stt_pkg::SLOT_W-1:0] pend_slot_q, pend_slot_d;

  // result register
  logic                       res_vld_q, res_vld_d;
  logic [stt_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;
  logic                       res_exp_q, res_exp_d;
  logic                       res_err_q, res_err_d;
  logic                       res_run_q, res_run_d;
  logic                       res_last_q, res_last_d;

  logic              accept;
  stt_pkg::idx_t     op_idx;
  stt_pkg::idx_t     proc_idx;
  logic              inrange;
  logic              used;
  stt_pkg::mem_req_t mem_req;
  stt_pkg::count_t   rd_cnt;
  stt_pkg::count_t   rd_rel;
  stt_pkg::dec_res_t dec_res;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign op_idx   = stt_pkg::IDX_W'(slot_q);
  assign proc_idx = stt_pkg::IDX_W'(stt_pkg::WALK_W'(walk_q - 1'b1));
  assign inrange  = (32'(slot_q) < 32'(stt_pkg::NUM_SLOTS));
  assign used     = inrange && valid_q[op_idx];

  stt_mem u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_cnt_o (rd_cnt),
    .rd_rel_o (rd_rel)
  );

  stt_dec u_dec (
    .cnt_i    (rd_cnt),
    .reload_i (rd_rel),
    .res_o    (dec_res)
  );

  // sequencer and slot updates
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    en_d        = en_q;
    arl_d       = arl_q;
    ticks_d     = ticks_q;
    walk_d      = walk_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    res_vld_d   = 1'b0;
    res_slot_d  = res_slot_q;
    res_exp_d   = res_exp_q;
    res_err_d   = res_err_q;
    res_run_d   = res_run_q;
    res_last_d  = res_last_q;
    mem_req.rd_addr = op_idx;
    mem_req.we_cnt  = 1'b0;
    mem_req.we_rel  = 1'b0;
    mem_req.wr_addr = op_idx;
    mem_req.wr_cnt  = rel_val_q;
    mem_req.wr_rel  = rel_val_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (func_i == stt_pkg::FN_TICK) begin
            ticks_d    = ticks_q + 1'b1;
            walk_d     = '0;
            pend_vld_d = 1'b0;
            state_d    = S_WALK;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_EX;
      end
      S_EX: begin
        res_vld_d  = 1'b1;
        res_slot_d = slot_q;
        res_exp_d  = 1'b0;
        res_err_d  = 1'b0;
        res_run_d  = 1'b0;
        res_last_d = 1'b1;
        state_d    = S_IDLE;
        case (func_q)
          stt_pkg::FN_CREATE: begin
            if (!inrange || valid_q[op_idx]) begin
              res_err_d = 1'b1;
            end else begin
              valid_d[op_idx] = 1'b1;
              arl_d[op_idx]   = ar_q;
              en_d[op_idx]    = sr_q;
              mem_req.we_cnt  = 1'b1;
              mem_req.we_rel  = 1'b1;
            end
          end
          stt_pkg::FN_REMOVE: begin
            if (!used) begin
              res_err_d = 1'b1;
            end else begin
              valid_d[op_idx] = 1'b0;
              en_d[op_idx]    = 1'b0;
            end
          end
          stt_pkg::FN_PAUSE: begin
            if (!used) begin
              res_err_d = 1'b1;
            end else begin
              en_d[op_idx] = 1'b0;
            end
          end
          stt_pkg::FN_RESUME: begin
            if (!used) begin
              res_err_d = 1'b1;
            end else begin
              en_d[op_idx] = 1'b1;
            end
          end
          stt_pkg::FN_RESET: begin
            if (!used) begin
              res_err_d = 1'b1;
            end else begin
              en_d[op_idx]   = 1'b1;
              mem_req.we_cnt = 1'b1;
              mem_req.wr_cnt = rd_rel;
            end
          end
          stt_pkg::FN_QUERY: begin
            if (!used) begin
              res_err_d = 1'b1;
            end else begin
              res_run_d = en_q[op_idx];
            end
          end
          default: begin
            res_err_d = 1'b1;
          end
        endcase
      end
      S_WALK: begin
        // read the slot at walk_q, update the one read last cycle
        mem_req.rd_addr = stt_pkg::IDX_W'(walk_q);
        if ((walk_q != '0) && valid_q[proc_idx] && en_q[proc_idx]) begin
          mem_req.we_cnt  = 1'b1;
          mem_req.wr_addr = proc_idx;
          mem_req.wr_cnt  = dec_res.next_cnt;
          if (dec_res.hit) begin
            if (!arl_q[proc_idx]) begin
              en_d[proc_idx] = 1'b0;
            end
            // an earlier expiry goes out now, it is not the final one
            if (pend_vld_q) begin
              res_vld_d  = 1'b1;
              res_slot_d = pend_slot_q;
              res_exp_d  = 1'b1;
              res_err_d  = 1'b0;
              res_run_d  = 1'b0;
              res_last_d = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_slot_d = stt_pkg::SLOT_W'(proc_idx);
          end
        end
        if (walk_q == stt_pkg::WALK_W'(stt_pkg::NUM_SLOTS)) begin
          state_d = S_FIN;
        end else begin
          walk_d = stt_pkg::WALK_W'(walk_q + 1'b1);
        end
      end
      S_FIN: begin
        // final beat of a tick: held expiry or a plain tick report
        res_vld_d  = 1'b1;
        res_slot_d = pend_vld_q ? pend_slot_q : '0;
        res_exp_d  = pend_vld_q;
        res_err_d  = 1'b0;
        res_run_d  = 1'b0;
        res_last_d = 1'b1;
        pend_vld_d = 1'b0;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      en_q       <= '0;
      arl_q      <= '0;
      ticks_q    <= '0;
      walk_q     <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      en_q       <= en_d;
      arl_q      <= arl_d;
      ticks_q    <= ticks_d;
      walk_q     <= walk_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_i;
      slot_q    <= slot_i;
      rel_val_q <= stt_pkg::COUNT_BITS'(reload_value_i);
      ar_q      <= auto_reload_i;
      sr_q      <= start_running_i;
    end
    pend_slot_q <= pend_slot_d;
    res_slot_q  <= res_slot_d;
    res_exp_q   <= res_exp_d;
    res_err_q   <= res_err_d;
    res_run_q   <= res_run_d;
    res_last_q  <= res_last_d;
  end

  assign res_strobe_o = res_vld_q;
  assign timer_slot_o = res_slot_q;
  assign expired_o    = res_exp_q;
  assign error_o      = res_err_q;
  assign running_o    = res_run_q;
  assign ticks_o      = ticks_q;
  assign last_o       = res_last_q;

endmodule

// ----- design/stt_checker.sv -----
// port-level checks of the soft timer table and their binding
`include "soft_timer_table_unit_defines.svh"

module stt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_strobe_o,
  input logic expired_o,
  input logic error_o,
  input logic running_o,
  input logic last_o
);

  // an accepted beat makes the unit busy
  `STT_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "accept did not raise busy")

  // more beats of the same item follow while busy
  `STT_ASSERT(a_more_busy, clk_i, rst_ni, res_strobe_o && !last_o |-> busy, "non-final beat while idle")

  // an expiry beat carries no error and no run flag
  `STT_ASSERT(a_exp_clean, clk_i, rst_ni, res_strobe_o && expired_o |-> !error_o && !running_o, "expiry beat has error or run flag")

  // the final beat of an item is never directly followed by another beat
  `STT_ASSERT(a_last_gap, clk_i, rst_ni, res_strobe_o && last_o |=> !res_strobe_o, "beat right after final beat")

  // reset leaves the unit idle and quiet
  `STT_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !busy && !res_strobe_o, "not idle after reset")

endmodule

bind soft_timer_table_unit stt_checker u_stt_checker (.*);
